// ----- src/mlk_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlk_pkg
// Shared types, constants and the character code table of the Morse keyer.
// ----------------------------------------------------------------------------
package mlk_pkg;

    localparam int unsigned PERIOD_W     = 14;
    localparam int unsigned DUR_W        = 15;
    localparam int unsigned GAP_W        = 12;
    localparam int unsigned CODE_MAX     = 5;
    localparam int unsigned LEN_W        = 3;
    localparam int unsigned STEP_W       = 4;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 14'd10000;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 14'd1;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 14'd500;
    localparam logic [DUR_W-1:0]    DASH_RESET   = 15'd1500;
    localparam logic [GAP_W-1:0]    GAP_RESET    = 12'd166;

    // floor(x / 3) = (x * ceil(2^17 / 3)) >> 17, exact for x below 2^17
    localparam int unsigned         RECIP_SHIFT  = 17;
    localparam int unsigned         RECIP_W      = 16;
    localparam logic [RECIP_W-1:0]  RECIP_THIRD  = 16'd43691;
    localparam int unsigned         PROD_W       = PERIOD_W + RECIP_W;

    localparam int unsigned         Q_DEPTH      = 2;
    localparam int unsigned         Q_AW         = 1;
    localparam int unsigned         Q_CW         = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        ELEM_DOT   = 2'd0,
        ELEM_DASH  = 2'd1,
        ELEM_GAP   = 2'd2,
        ELEM_LGAP  = 2'd3
    } elem_t;

    // classified character, one queue entry
    typedef struct packed {
        logic                bad;
        logic [LEN_W-1:0]    len;
        logic [CODE_MAX-1:0] pattern;   // bit i set: element i is a dash
        logic                fin;
    } chr_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] dot;
        logic [DUR_W-1:0]    dash;
        logic [GAP_W-1:0]    gap;
    } timing_t;

    typedef struct packed {
        logic             led_on;
        logic [DUR_W-1:0] duration;
        elem_t            element;
        logic             bad;
        logic             run_last;
        logic             msg_end;
    } seg_t;

    function automatic chr_t classify(input logic [7:0] c, input logic fin);
        chr_t r;
        r.bad     = 1'b0;
        r.len     = 3'd0;
        r.pattern = 5'b00000;
        r.fin     = fin;
        case (c)
            8'h61: begin r.len = 3'd2; r.pattern = 5'b00010; end // a
            8'h62: begin r.len = 3'd4; r.pattern = 5'b00001; end // b
            8'h63: begin r.len = 3'd4; r.pattern = 5'b00101; end // c
            8'h64: begin r.len = 3'd3; r.pattern = 5'b00001; end // d
            8'h65: begin r.len = 3'd1; r.pattern = 5'b00000; end // e
            8'h66: begin r.len = 3'd4; r.pattern = 5'b00100; end // f
            8'h67: begin r.len = 3'd3; r.pattern = 5'b00011; end // g
            8'h68: begin r.len = 3'd4; r.pattern = 5'b00000; end // h
            8'h69: begin r.len = 3'd2; r.pattern = 5'b00000; end // i
            8'h6a: begin r.len = 3'd4; r.pattern = 5'b01110; end // j
            8'h6b: begin r.len = 3'd3; r.pattern = 5'b00101; end // k
            8'h6c: begin r.len = 3'd4; r.pattern = 5'b00010; end // l
            8'h6d: begin r.len = 3'd2; r.pattern = 5'b00011; end // m
            8'h6e: begin r.len = 3'd2; r.pattern = 5'b00001; end // n
            8'h6f: begin r.len = 3'd3; r.pattern = 5'b00111; end // o
            8'h70: begin r.len = 3'd4; r.pattern = 5'b00110; end // p
            8'h71: begin r.len = 3'd4; r.pattern = 5'b01011; end // q
            8'h72: begin r.len = 3'd3; r.pattern = 5'b00010; end // r
            8'h73: begin r.len = 3'd3; r.pattern = 5'b00000; end // s
            8'h74: begin r.len = 3'd1; r.pattern = 5'b00001; end // t
            8'h75: begin r.len = 3'd3; r.pattern = 5'b00100; end // u
            8'h76: begin r.len = 3'd4; r.pattern = 5'b01000; end // v
            8'h77: begin r.len = 3'd3; r.pattern = 5'b00110; end // w
            8'h78: begin r.len = 3'd4; r.pattern = 5'b01001; end // x
            8'h79: begin r.len = 3'd4; r.pattern = 5'b01101; end // y
            8'h7a: begin r.len = 3'd4; r.pattern = 5'b00011; end // z
            8'h30: begin r.len = 3'd5; r.pattern = 5'b11111; end // 0
            8'h31: begin r.len = 3'd5; r.pattern = 5'b11110; end // 1
            8'h32: begin r.len = 3'd5; r.pattern = 5'b11100; end // 2
            8'h33: begin r.len = 3'd5; r.pattern = 5'b11000; end // 3
            8'h34: begin r.len = 3'd5; r.pattern = 5'b10000; end // 4
            8'h35: begin r.len = 3'd5; r.pattern = 5'b00000; end // 5
            8'h36: begin r.len = 3'd5; r.pattern = 5'b00001; end // 6
            8'h37: begin r.len = 3'd5; r.pattern = 5'b00011; end // 7
            8'h38: begin r.len = 3'd5; r.pattern = 5'b00111; end // 8
            8'h39: begin r.len = 3'd5; r.pattern = 5'b01111; end // 9
            default: begin
                r.bad = 1'b1;
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/mlk_period.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlk_period
// Period register: clamps the written dot length and derives dash and gap.
// ----------------------------------------------------------------------------
module mlk_period
    import mlk_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wen,
    input  wire logic [PERIOD_W-1:0] cfg_wdata,
    output timing_t                  timing
);

    timing_t             timing_reg;
    timing_t             timing_next;
    logic [PERIOD_W-1:0] dot_clamped;
    logic [PROD_W-1:0]   third_prod;

    always_comb begin
        if (cfg_wdata > PERIOD_MAX) begin
            dot_clamped = PERIOD_MAX;
        end else if (cfg_wdata == '0) begin
            dot_clamped = PERIOD_MIN;
        end else begin
            dot_clamped = cfg_wdata;
        end
        third_prod  = PROD_W'(dot_clamped) * PROD_W'(RECIP_THIRD);
        timing_next.dot  = dot_clamped;
        timing_next.dash = DUR_W'(dot_clamped) + {dot_clamped, 1'b0};
        timing_next.gap  = third_prod[RECIP_SHIFT +: GAP_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timing_reg.dot  <= PERIOD_RESET;
            timing_reg.dash <= DASH_RESET;
            timing_reg.gap  <= GAP_RESET;
        end else if (cfg_wen) begin
            timing_reg <= timing_next;
        end
    end

    assign timing = timing_reg;

endmodule
`default_nettype wire

// ----- src/mlk_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlk_front
// Input side: takes a character word and classifies it into a code entry.
// ----------------------------------------------------------------------------
module mlk_front
    import mlk_pkg::*;
(
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tlast,
    input  wire logic       q_full,
    output logic            q_push,
    output chr_t            q_entry
);

    always_comb begin
        s_tready = !q_full;
        q_push   = s_tvalid && !q_full;
        q_entry  = classify(s_tdata, s_tlast);
    end

endmodule
`default_nettype wire

// ----- src/mlk_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlk_queue
// Two-entry queue of classified characters between front and sequencer.
// ----------------------------------------------------------------------------
module mlk_queue
    import mlk_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire chr_t push_entry,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output chr_t      head
);

    chr_t              mem [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_next;
    logic [Q_CW-1:0]   count_reg;
    logic [Q_CW-1:0]   count_next;

    always_comb begin
        full        = (count_reg == Q_CW'(Q_DEPTH));
        head_valid  = (count_reg != '0);
        head        = mem[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/mlk_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlk_sequencer
// Back end: steps through the head character's elements, one segment word a
// cycle while the output does not stall, into the output register.
// ----------------------------------------------------------------------------
module mlk_sequencer
    import mlk_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    head_valid,
    input  wire chr_t    head,
    output logic         pop,
    input  wire timing_t timing,
    output logic         m_valid,
    input  wire logic    m_ready,
    output seg_t         m_seg
);

    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    seg_t                seg_reg;
    seg_t                seg_next;
    logic                out_ready;
    logic                fire;
    logic                final_seg;
    logic                lgap;
    logic [CODE_MAX-1:0] pat_shift;
    logic                dash;

    always_comb begin
        out_ready = !m_valid_reg || m_ready;
        fire      = head_valid && out_ready;
        lgap      = (step_reg == {head.len, 1'b0});
        final_seg = head.bad || lgap;
        pop       = fire && final_seg;
        pat_shift = head.pattern >> step_reg[STEP_W-1:1];
        dash      = pat_shift[0];

        seg_next.bad      = 1'b0;
        seg_next.run_last = 1'b0;
        seg_next.msg_end  = 1'b0;
        if (head.bad) begin
            seg_next.led_on   = 1'b0;
            seg_next.duration = '0;
            seg_next.element  = ELEM_DOT;
            seg_next.bad      = 1'b1;
            seg_next.run_last = 1'b1;
            seg_next.msg_end  = head.fin;
        end else if (lgap) begin
            seg_next.led_on   = 1'b0;
            seg_next.duration = DUR_W'(timing.dot);
            seg_next.element  = ELEM_LGAP;
            seg_next.run_last = 1'b1;
            seg_next.msg_end  = head.fin;
        end else if (!step_reg[0]) begin
            seg_next.led_on   = 1'b1;
            seg_next.duration = dash ? timing.dash : DUR_W'(timing.dot);
            seg_next.element  = dash ? ELEM_DASH : ELEM_DOT;
        end else begin
            seg_next.led_on   = 1'b0;
            seg_next.duration = DUR_W'(timing.gap);
            seg_next.element  = ELEM_GAP;
        end

        // hold the step while the output stalls; restart at each new character
        step_next = step_reg;
        if (fire) begin
            step_next = final_seg ? '0 : step_reg + 1'b1;
        end

        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            seg_reg <= seg_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_seg   = seg_reg;

endmodule
`default_nettype wire

// ----- src/morse_letter_keyer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// morse_letter_keyer
// Turns one ASCII character into a run of timed light segments (ITU Morse).
//
//   channel  dir  word                         sideband
//   s_       in   tdata[7:0] char_code         tlast last_letter
//   m_       out  tdata led_on, duration_ms    tuser element, bad_char,
//                                              message_end; tlast run_last
//   cfg_     in   wdata period_ms, write on cfg_wen
//
// The sequencer emits one segment a cycle unless m_tready stalls it: a letter
// or digit with n elements gives 2n+1 segments (3 to 11), any other char one.
// A two-entry queue lets the next characters be taken while a run is sent;
// a stall on m_tready holds the output word and the sequencer step.
// Reset empties the queue, clears the output valid and sets the period to
// 500 ms (dash 1500, gap 166).
// ----------------------------------------------------------------------------
module morse_letter_keyer
    import mlk_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,   // [7:0] char_code
    input  wire logic                s_tlast,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [15:0]              m_tdata,   // [0] led_on, [15:1] duration_ms
    output logic [3:0]               m_tuser,   // [1:0] element, [2] bad_char,
                                                // [3] message_end
    output logic                     m_tlast,
    input  wire logic                cfg_wen,
    input  wire logic [PERIOD_W-1:0] cfg_wdata
);

    timing_t timing;
    logic    q_full;
    logic    q_push;
    chr_t    q_entry;
    logic    q_pop;
    logic    q_head_valid;
    chr_t    q_head;
    seg_t    seg;

    mlk_period u_period (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .timing    (timing)
    );

    mlk_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    mlk_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    mlk_sequencer u_sequencer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .timing     (timing),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_seg      (seg)
    );

    assign m_tdata = {seg.duration, seg.led_on};
    assign m_tuser = {seg.msg_end, seg.bad, seg.element};
    assign m_tlast = seg.run_last;

endmodule
`default_nettype wire

// ----- bench/morse_segment_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_segment_checker
// Watches the character, segment and period channels of the Morse keyer.
// Every accepted character is turned into the light segments it should
// cause, and each segment that leaves the block is compared field by field
// with the oldest one still due.
// ----------------------------------------------------------------------------
module morse_segment_checker
    import mlk_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    input  wire logic                s_tready,
    input  wire logic [7:0]          s_tdata,   // [7:0] char_code
    input  wire logic                s_tlast,
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic [15:0]         m_tdata,   // [0] led_on, [15:1] duration_ms
    input  wire logic [3:0]          m_tuser,   // [1:0] element, [2] bad_char,
                                                // [3] message_end
    input  wire logic                m_tlast,
    input  wire logic                cfg_wen,
    input  wire logic [PERIOD_W-1:0] cfg_wdata,
    output int                       fail_count,
    output int                       pending
);

    typedef struct {
        logic             led_on;
        logic [DUR_W-1:0] duration;
        elem_t            element;
        logic             bad_char;
        logic             run_last;
        logic             msg_end;
    } light_seg_t;

    light_seg_t          segment_q[$];
    light_seg_t          due_seg;
    logic [PERIOD_W-1:0] dot_period;
    int                  errors = 0;

    assign fail_count = errors;

    // ITU code of a lower-case letter or digit, empty when there is none
    function automatic string morse_of(input logic [7:0] c);
        case (c)
            "a": return ".-";
            "b": return "-...";
            "c": return "-.-.";
            "d": return "-..";
            "e": return ".";
            "f": return "..-.";
            "g": return "--.";
            "h": return "....";
            "i": return "..";
            "j": return ".---";
            "k": return "-.-";
            "l": return ".-..";
            "m": return "--";
            "n": return "-.";
            "o": return "---";
            "p": return ".--.";
            "q": return "--.-";
            "r": return ".-.";
            "s": return "...";
            "t": return "-";
            "u": return "..-";
            "v": return "...-";
            "w": return ".--";
            "x": return "-..-";
            "y": return "-.--";
            "z": return "--..";
            "0": return "-----";
            "1": return ".----";
            "2": return "..---";
            "3": return "...--";
            "4": return "....-";
            "5": return ".....";
            "6": return "-....";
            "7": return "--...";
            "8": return "---..";
            "9": return "----.";
            default: return "";
        endcase
    endfunction

    task automatic push_seg(input logic led, input int unsigned dur, input elem_t el,
                            input logic bad, input logic rl, input logic me);
        light_seg_t s;
        s.led_on   = led;
        s.duration = dur[DUR_W-1:0];
        s.element  = el;
        s.bad_char = bad;
        s.run_last = rl;
        s.msg_end  = me;
        segment_q.push_back(s);
    endtask

    task automatic queue_segments(input logic [7:0] c, input logic fin);
        string       code;
        int unsigned p;
        p = dot_period;
        // clamp the period into its legal range
        if (p > PERIOD_MAX)
            p = PERIOD_MAX;
        if (p == 0)
            p = 1;
        code = morse_of(c);
        if (code.len() == 0) begin
            push_seg(1'b0, 0, ELEM_DOT, 1'b1, 1'b1, fin);
            return;
        end
        for (int i = 0; i < code.len(); i++) begin
            if (code[i] == "-")
                push_seg(1'b1, p * 3, ELEM_DASH, 1'b0, 1'b0, 1'b0);
            else
                push_seg(1'b1, p, ELEM_DOT, 1'b0, 1'b0, 1'b0);
            push_seg(1'b0, p / 3, ELEM_GAP, 1'b0, 1'b0, 1'b0);
        end
        push_seg(1'b0, p, ELEM_LGAP, 1'b0, 1'b1, fin);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            dot_period = PERIOD_RESET;
            segment_q.delete();
        end else begin
            if (cfg_wen)
                dot_period = cfg_wdata;
            if (s_tvalid && s_tready)
                queue_segments(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (segment_q.size() == 0) begin
                    $error("segment word with nothing due: tdata %h tuser %h tlast %b",
                           m_tdata, m_tuser, m_tlast);
                    errors++;
                end else begin
                    due_seg = segment_q.pop_front();
                    check_field("led_on", due_seg.led_on, m_tdata[0]);
                    check_field("duration_ms", due_seg.duration, m_tdata[15:1]);
                    check_field("element", due_seg.element, m_tuser[1:0]);
                    check_field("bad_char", due_seg.bad_char, m_tuser[2]);
                    check_field("message_end", due_seg.msg_end, m_tuser[3]);
                    check_field("run_last", due_seg.run_last, m_tlast);
                end
            end
        end
        pending <= segment_q.size();
    end

endmodule

// ----- bench/tb_morse_letter_keyer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_morse_letter_keyer
// Drives characters into the Morse keyer in bursts while the segment side
// stalls on its own pattern, and steps the dot period through its extremes
// between phases. The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module tb_morse_letter_keyer;
    import mlk_pkg::*;

    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam int         ITEMS_PER_PHASE = 22;
    localparam int         SETTLE_CYCLES   = 16;

    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_RUNS
    } ready_mode_e;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [15:0]         m_tdata;
    logic [3:0]          m_tuser;
    logic                m_tlast;
    logic                cfg_wen;
    logic [PERIOD_W-1:0] cfg_wdata;
    int                  fail_count;
    int                  pending;

    morse_letter_keyer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    morse_segment_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("tb_morse_letter_keyer: errors");
        $finish;
    end

    // segment side: switch between stall patterns
    initial begin : ready_pattern
        ready_mode_e mode;
        int          mode_left;
        int          hold;
        logic        ready_run;
        mode      = RDY_ALWAYS;
        mode_left = 0;
        hold      = 0;
        ready_run = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (mode_left == 0) begin
                mode      = ready_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(64, 256);
            end
            mode_left--;
            case (mode)
                RDY_ALWAYS: m_tready <= 1'b1;
                RDY_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RDY_SPARSE: m_tready <= ($urandom_range(0, 4) == 0);
                default: begin
                    if (hold == 0) begin
                        ready_run = !ready_run;
                        hold = ready_run ? $urandom_range(1, 8) : $urandom_range(1, 12);
                    end
                    hold--;
                    m_tready <= ready_run;
                end
            endcase
        end
    end

    // present one word and hold it until taken
    task automatic send_char(input logic [7:0] c, input logic fin);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= fin;
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(0, 255));
            s_tlast  <= 1'($urandom_range(0, 1));
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic drain_out();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write the period only once every segment has left the block
    task automatic write_period(input logic [PERIOD_W-1:0] value);
        drain_out();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        cfg_wdata <= PERIOD_W'($urandom_range(0, 16383));
    endtask

    function automatic logic [7:0] pick_char();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return CH_LOWER_A + 8'($urandom_range(0, 25));
        if (roll < 70)
            return CH_ZERO + 8'($urandom_range(0, 9));
        if (roll < 85)
            return 8'($urandom_range(0, 255));
        // hug the edges of the coded ranges
        case ($urandom_range(0, 5))
            0: return CH_UPPER_A + 8'($urandom_range(0, 25));
            1: return CH_LOWER_A - 8'd1;
            2: return CH_LOWER_A + 8'd26;
            3: return CH_ZERO - 8'd1;
            4: return CH_ZERO + 8'd10;
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    task automatic random_phase(input int items);
        int   sent;
        int   burst_left;
        int   msg_len;
        logic fin;
        sent       = 0;
        burst_left = $urandom_range(1, 12);
        while (sent < items) begin
            msg_len = $urandom_range(1, 8);
            // cut the last message short so the phase sends exactly its share
            if (msg_len > items - sent)
                msg_len = items - sent;
            for (int i = 0; i < msg_len; i++) begin
                fin = (i == msg_len - 1) ? 1'b1 : ($urandom_range(0, 15) == 0);
                send_char(pick_char(), fin);
                sent++;
                burst_left--;
                if (burst_left == 0) begin
                    // a zero gap keeps the stream running back to back
                    if ($urandom_range(0, 3) != 0)
                        idle_gap($urandom_range(1, 20));
                    burst_left = $urandom_range(1, 12);
                end
            end
        end
    endtask

    initial begin
        logic [PERIOD_W-1:0] periods[10];
        periods = '{14'd1, 14'd0, 14'd2, 14'd10000, 14'd16383, 14'd10001,
                    14'd3, 14'd9999, 14'd500, 14'd7};
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        s_tlast   <= 1'b0;
        cfg_wen   <= 1'b0;
        cfg_wdata <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed, at the reset period
        send_char("a", 1'b0);
        send_char("z", 1'b1);
        send_char("0", 1'b0);
        send_char("9", 1'b1);
        idle_gap(3);
        send_char("e", 1'b0);
        send_char("t", 1'b1);
        send_char("5", 1'b0);
        send_char("g", 1'b0);
        send_char("v", 1'b0);
        send_char("w", 1'b0);
        send_char("y", 1'b1);
        idle_gap(5);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char("A", 1'b0);
        send_char(CH_LOWER_A - 8'd1, 1'b1);
        send_char(CH_LOWER_A + 8'd26, 1'b0);
        send_char(CH_ZERO - 8'd1, 1'b0);
        send_char(CH_ZERO + 8'd10, 1'b1);
        send_char(8'h80, 1'b0);
        send_char(8'h7F, 1'b1);
        send_char("1", 1'b0);

        write_period(14'd1);
        send_char("0", 1'b1);
        send_char("h", 1'b0);
        write_period(14'd16383);
        send_char("0", 1'b1);
        send_char("5", 1'b1);

        foreach (periods[k]) begin
            write_period(periods[k]);
            random_phase(ITEMS_PER_PHASE / 2);
        end
        for (int k = 0; k < 6; k++) begin
            if (k % 2 == 0)
                write_period(PERIOD_W'($urandom_range(1, 10000)));
            else
                write_period(PERIOD_W'($urandom_range(0, 16383)));
            random_phase(ITEMS_PER_PHASE);
        end

        drain_out();
        repeat (40) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_morse_letter_keyer: clean");
        else
            $display("tb_morse_letter_keyer: errors");
        $finish;
    end

endmodule
